FILE: rtl/core/pr384_pkg.sv
`timescale 1ns / 1ps

package pr384_pkg;

  // Operation codes
  localparam logic [2:0] OP_ROUND_RC   = 3'd0;
  localparam logic [2:0] OP_ROUND      = 3'd1;
  localparam logic [2:0] OP_INV_ROUND  = 3'd2;
  localparam logic [2:0] OP_LINEAR     = 3'd3;
  localparam logic [2:0] OP_LINEAR_T   = 3'd4;

  localparam int unsigned NUM_ROUNDS = 24;

  // Request beat
  typedef struct packed {
    logic [2:0]  operation;
    logic [4:0]  round_index;
    logic [63:0] a_high;
    logic [63:0] a_low;
    logic [63:0] b_high;
    logic [63:0] b_low;
    logic [63:0] c_high;
    logic [63:0] c_low;
  } req_beat_t;

  // Response beat
  typedef struct packed {
    logic [63:0] new_a_high;
    logic [63:0] new_a_low;
    logic [63:0] new_b_high;
    logic [63:0] new_b_low;
    logic [63:0] new_c_high;
    logic [63:0] new_c_low;
  } rsp_beat_t;

  // Round constants; indices past the last round give zero
  function automatic logic [31:0] round_const(input logic [4:0] idx);
    logic [31:0] rc;
    case (idx)
      5'd0:    rc = 32'h0000_1111;
      5'd1:    rc = 32'h1110_0000;
      5'd2:    rc = 32'h0000_1101;
      5'd3:    rc = 32'h1010_0000;
      5'd4:    rc = 32'h0000_0101;
      5'd5:    rc = 32'h1011_0000;
      5'd6:    rc = 32'h0000_0110;
      5'd7:    rc = 32'h1100_0000;
      5'd8:    rc = 32'h0000_1001;
      5'd9:    rc = 32'h0010_0000;
      5'd10:   rc = 32'h0000_0100;
      5'd11:   rc = 32'h1000_0000;
      5'd12:   rc = 32'h0000_0001;
      5'd13:   rc = 32'h0011_0000;
      5'd14:   rc = 32'h0000_0111;
      5'd15:   rc = 32'h1111_0000;
      5'd16:   rc = 32'h0000_1110;
      5'd17:   rc = 32'h1101_0000;
      5'd18:   rc = 32'h0000_1010;
      5'd19:   rc = 32'h0101_0000;
      5'd20:   rc = 32'h0000_1011;
      5'd21:   rc = 32'h0110_0000;
      5'd22:   rc = 32'h0000_1100;
      5'd23:   rc = 32'h1001_0000;
      default: rc = 32'h0000_0000;
    endcase
    return rc;
  endfunction

  // Rotations by fixed amounts used in the round (wiring only)
  function automatic logic [127:0] rol1(input logic [127:0] x);
    return {x[126:0], x[127]};
  endfunction

  function automatic logic [127:0] rol36(input logic [127:0] x);
    return {x[91:0], x[127:92]};
  endfunction

  function automatic logic [127:0] rol48(input logic [127:0] x);
    return {x[79:0], x[127:80]};
  endfunction

  function automatic logic [127:0] rol67(input logic [127:0] x);
    return {x[60:0], x[127:61]};
  endfunction

  function automatic logic [127:0] rol80(input logic [127:0] x);
    return {x[47:0], x[127:48]};
  endfunction

  function automatic logic [127:0] rol127(input logic [127:0] x);
    return {x[0], x[127:1]};
  endfunction

endpackage

FILE: rtl/core/pr384_round.sv
`timescale 1ns / 1ps

// Combinational round datapath: all five operations, selected at the end
module pr384_round (
  input  pr384_pkg::req_beat_t req,
  output pr384_pkg::rsp_beat_t rsp
);

  logic [127:0] a, b, c, c_in;
  logic [31:0]  rc;

  // forward linear layer
  logic [127:0] l_a, l_b0, l_c, l_b;
  logic [127:0] r_a;
  // inverse round
  logic [127:0] i_a, i_b0, i_c, i_b1;
  // transposed linear layer
  logic [127:0] t_a, t_c0, t_b, t_c;

  logic [127:0] o_a, o_b, o_c;

  assign a  = {req.a_high, req.a_low};
  assign b  = {req.b_high, req.b_low};
  assign c  = {req.c_high, req.c_low};
  assign rc = (req.operation == pr384_pkg::OP_ROUND_RC) ?
              pr384_pkg::round_const(req.round_index) : 32'h0;

  // constant goes into the lowest word of c (zero for the other ops)
  assign c_in = c ^ {96'h0, rc};

  // linear layer: limb rotation, two mixing steps, sum
  assign l_a  = a ^ b ^ c_in;
  assign l_b0 = c_in ^ pr384_pkg::rol1(a);
  assign l_c  = a ^ pr384_pkg::rol80(l_b0);
  assign l_b  = l_a ^ l_b0 ^ l_c;

  // nonlinear step on top of the linear layer
  assign r_a = l_a ^ (pr384_pkg::rol36(l_b) & pr384_pkg::rol67(l_c));

  // inverse round: undo the AND, then the mixing in reverse
  assign i_a  = a ^ (pr384_pkg::rol36(b) & pr384_pkg::rol67(c));
  assign i_b0 = b ^ i_a ^ c;
  assign i_c  = c ^ pr384_pkg::rol80(i_b0);
  assign i_b1 = i_b0 ^ pr384_pkg::rol1(i_c);

  // transposed linear layer
  assign t_a  = a ^ b;
  assign t_c0 = c ^ b;
  assign t_b  = b ^ pr384_pkg::rol48(t_c0);
  assign t_c  = t_c0 ^ pr384_pkg::rol127(t_b);

  // result selection; unused codes pass the state through
  always_comb begin
    case (req.operation)
      pr384_pkg::OP_ROUND_RC, pr384_pkg::OP_ROUND: begin
        o_a = r_a;
        o_b = l_b;
        o_c = l_c;
      end
      pr384_pkg::OP_INV_ROUND: begin
        o_a = i_c;
        o_b = i_a ^ i_c ^ i_b1;
        o_c = i_b1;
      end
      pr384_pkg::OP_LINEAR: begin
        o_a = l_a;
        o_b = l_b;
        o_c = l_c;
      end
      pr384_pkg::OP_LINEAR_T: begin
        o_a = t_a ^ t_c;
        o_b = t_a;
        o_c = t_a ^ t_b;
      end
      default: begin
        o_a = a;
        o_b = b;
        o_c = c;
      end
    endcase
  end

  assign rsp.new_a_high = o_a[127:64];
  assign rsp.new_a_low  = o_a[63:0];
  assign rsp.new_b_high = o_b[127:64];
  assign rsp.new_b_low  = o_b[63:0];
  assign rsp.new_c_high = o_c[127:64];
  assign rsp.new_c_low  = o_c[63:0];

endmodule

FILE: rtl/core/permutation_round_384_unit.sv
`timescale 1ns / 1ps

// One round step of a 384-bit permutation (three 128-bit limbs a, b, c).
// Request channel: req_valid / req_stall carry one state plus an operation
// code (round with constant, bare round, inverse round, linear layer,
// transposed linear layer) and a round index; a beat is taken when
// req_valid is high and req_stall is low.
// Response channel: rsp_valid / rsp_stall carry the new state, one response
// beat for every request beat, in order.
// Path: a taken request beat is held in the input register, then goes through
// the round logic into the output register, which presents the response.
// Throughput: one beat per cycle while the receiver does not stall, set by the
// single registered pass through the round logic.
// When the receiver stalls, the output register holds its beat steady and
// the input register can still take one more beat; req_stall rises only
// when both are full and the output is not being drained.
// Reset (rst, synchronous) empties both registers; rsp_valid is low after.
module permutation_round_384_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  pr384_pkg::req_beat_t  req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output pr384_pkg::rsp_beat_t  rsp
);

  logic                 in_valid;
  pr384_pkg::req_beat_t in_beat;
  pr384_pkg::rsp_beat_t round_out;
  logic                 out_load;
  logic                 in_load;

  // output register free or being drained
  assign out_load  = !rsp_valid || !rsp_stall;
  assign req_stall = in_valid && !out_load;
  assign in_load   = req_valid && !req_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= 1'b1;
    end else if (out_load) begin
      in_valid <= 1'b0;
    end
    if (in_load) begin
      in_beat <= req;
    end
  end

  pr384_round u_round (
    .req (in_beat),
    .rsp (round_out)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= in_valid;
    end
    if (out_load && in_valid) begin
      rsp <= round_out;
    end
  end

endmodule

FILE: rtl/core/pr384_checker.sv
`timescale 1ns / 1ps

// Port-level checks on the round unit
module pr384_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_stall,
  input logic                 rsp_valid,
  input logic                 rsp_stall,
  input pr384_pkg::rsp_beat_t rsp
);

  // stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response beat changed");

  // nothing comes out straight after reset
  a_rsp_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // with the output empty the input is never stalled
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> !req_stall)
    else $error("request stalled with empty output");

  // a draining output frees the input in the same cycle
  a_no_stall_drain: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_stall |-> !req_stall)
    else $error("request stalled while output drains");

endmodule

bind permutation_round_384_unit pr384_checker u_pr384_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  typedef logic [127:0] limb_t;

  // Codes past the transposed linear layer pass the state through
  localparam logic [2:0] OP_MAX = 3'd7;

  localparam int unsigned NUM_ITEMS   = 850;
  localparam int unsigned IDLE_PCT    = 24;
  localparam int unsigned QUIET_FROM  = 300;
  localparam int unsigned QUIET_TO    = 500;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned DRAIN_LIMIT = 1000;

  localparam logic [31:0] ROUND_CONSTANTS [24] = '{
    32'h0000_1111, 32'h1110_0000, 32'h0000_1101, 32'h1010_0000,
    32'h0000_0101, 32'h1011_0000, 32'h0000_0110, 32'h1100_0000,
    32'h0000_1001, 32'h0010_0000, 32'h0000_0100, 32'h1000_0000,
    32'h0000_0001, 32'h0011_0000, 32'h0000_0111, 32'h1111_0000,
    32'h0000_1110, 32'h1101_0000, 32'h0000_1010, 32'h0101_0000,
    32'h0000_1011, 32'h0110_0000, 32'h0000_1100, 32'h1001_0000
  };

  // Works out the next state for each request beat and checks response beats in order
  class permutation_checker;
    pr384_pkg::rsp_beat_t expected_states[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    function limb_t rotl(limb_t x, int unsigned n);
      return (x << n) | (x >> (128 - n));
    endfunction

    function pr384_pkg::rsp_beat_t next_state(pr384_pkg::req_beat_t s);
      limb_t a, b, c, na, nb, nc;
      pr384_pkg::rsp_beat_t r;
      a = {s.a_high, s.a_low};
      b = {s.b_high, s.b_low};
      c = {s.c_high, s.c_low};
      case (s.operation)
        pr384_pkg::OP_ROUND_RC, pr384_pkg::OP_ROUND, pr384_pkg::OP_LINEAR: begin
          if (s.operation == pr384_pkg::OP_ROUND_RC &&
              s.round_index < pr384_pkg::NUM_ROUNDS)
            c[31:0] = c[31:0] ^ ROUND_CONSTANTS[s.round_index];
          // limb rotation and mixing
          na = a ^ b ^ c;
          nb = c ^ rotl(a, 1);
          nc = a ^ rotl(nb, 80);
          nb = na ^ nb ^ nc;
          a = na;
          b = nb;
          c = nc;
          if (s.operation != pr384_pkg::OP_LINEAR)
            a = a ^ (rotl(b, 36) & rotl(c, 67));
        end
        pr384_pkg::OP_INV_ROUND: begin
          a = a ^ (rotl(b, 36) & rotl(c, 67));
          b = b ^ a ^ c;
          c = c ^ rotl(b, 80);
          b = b ^ rotl(c, 1);
          na = c;
          nb = a ^ c ^ b;
          nc = b;
          a = na;
          b = nb;
          c = nc;
        end
        pr384_pkg::OP_LINEAR_T: begin
          a = a ^ b;
          c = c ^ b;
          b = b ^ rotl(c, 48);
          c = c ^ rotl(b, 127);
          na = a ^ c;
          nc = a ^ b;
          nb = a;
          a = na;
          b = nb;
          c = nc;
        end
        default: ;
      endcase
      {r.new_a_high, r.new_a_low} = a;
      {r.new_b_high, r.new_b_low} = b;
      {r.new_c_high, r.new_c_low} = c;
      return r;
    endfunction

    function void note_state(pr384_pkg::req_beat_t s);
      expected_states.push_back(next_state(s));
    endfunction

    function void compare_word(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        failures++;
      end
    endfunction

    function void check_state(pr384_pkg::rsp_beat_t got);
      pr384_pkg::rsp_beat_t want;
      if (expected_states.size() == 0) begin
        $error("response beat with no request outstanding");
        failures++;
        return;
      end
      want = expected_states.pop_front();
      compare_word("new_a_high", want.new_a_high, got.new_a_high);
      compare_word("new_a_low",  want.new_a_low,  got.new_a_low);
      compare_word("new_b_high", want.new_b_high, got.new_b_high);
      compare_word("new_b_low",  want.new_b_low,  got.new_b_low);
      compare_word("new_c_high", want.new_c_high, got.new_c_high);
      compare_word("new_c_low",  want.new_c_low,  got.new_c_low);
    endfunction

    function int unsigned pending();
      return expected_states.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  pr384_pkg::req_beat_t req;
  logic                 rsp_valid;
  logic                 rsp_stall;
  pr384_pkg::rsp_beat_t rsp;

  int unsigned idle_pct;
  logic        squeeze_req;
  logic        squeeze_done;
  int unsigned hold_left;

  permutation_checker sb = new();

  permutation_round_384_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Beat monitor: requests noted before responses are checked
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall)
        sb.note_state(req);
      if (rsp_valid && !rsp_stall)
        sb.check_state(rsp);
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    rsp_stall    = 1'b0;
    squeeze_done = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeeze_done) begin
        hold_left    = HOLD_CYCLES;
        squeeze_done = 1'b1;
      end
      if (hold_left > 0) begin
        rsp_stall = 1'b1;
        hold_left--;
      end else begin
        rsp_stall = ($urandom_range(0, 99) < idle_pct);
      end
    end
  end

  function automatic logic [63:0] random_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 64'h1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic pr384_pkg::req_beat_t random_state(logic [2:0] op, logic [4:0] idx);
    pr384_pkg::req_beat_t s;
    s.operation   = op;
    s.round_index = idx;
    s.a_high      = random_word();
    s.a_low       = random_word();
    s.b_high      = random_word();
    s.b_low       = random_word();
    s.c_high      = random_word();
    s.c_low       = random_word();
    return s;
  endfunction

  function automatic pr384_pkg::req_beat_t uniform_state(logic [2:0] op, logic [4:0] idx,
                                                         logic [63:0] w);
    pr384_pkg::req_beat_t s;
    s.operation   = op;
    s.round_index = idx;
    s.a_high      = w;
    s.a_low       = w;
    s.b_high      = w;
    s.b_low       = w;
    s.c_high      = w;
    s.c_low       = w;
    return s;
  endfunction

  // Offer one beat from a falling edge, return at the falling edge after it is taken
  task automatic send_state(input pr384_pkg::req_beat_t s);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req       = s;
    req_valid = 1'b1;
    @(posedge clk);
    while (req_stall)
      @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    pr384_pkg::req_beat_t s;
    logic [2:0]           op;
    int unsigned          waited;

    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    idle_pct    = IDLE_PCT;
    squeeze_req = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // every operation code, used or not
    for (int k = 0; k <= OP_MAX; k++)
      send_state(random_state(3'(k), 5'($urandom_range(0, 31))));

    // first and last round constants, and indices past the table
    send_state(uniform_state(pr384_pkg::OP_ROUND_RC, 5'd0, '0));
    send_state(uniform_state(pr384_pkg::OP_ROUND_RC, 5'(pr384_pkg::NUM_ROUNDS - 1), '0));
    send_state(uniform_state(pr384_pkg::OP_ROUND_RC, 5'(pr384_pkg::NUM_ROUNDS), '0));
    send_state(uniform_state(pr384_pkg::OP_ROUND_RC, '1, '0));

    // all-ones state through each operation
    send_state(uniform_state(pr384_pkg::OP_ROUND_RC, 5'd7, '1));
    send_state(uniform_state(pr384_pkg::OP_ROUND, '1, '1));
    send_state(uniform_state(pr384_pkg::OP_INV_ROUND, '0, '1));
    send_state(uniform_state(pr384_pkg::OP_LINEAR, '1, '1));
    send_state(uniform_state(pr384_pkg::OP_LINEAR_T, '0, '1));

    // lone bits at the limb ends to expose rotation wiring
    s        = uniform_state(pr384_pkg::OP_INV_ROUND, '0, '0);
    s.a_high = 64'h8000_0000_0000_0000;
    s.c_low  = 64'h1;
    send_state(s);
    s           = uniform_state(pr384_pkg::OP_LINEAR_T, '0, '0);
    s.b_low     = 64'h1;
    s.c_high    = 64'h8000_0000_0000_0000;
    send_state(s);
    s           = uniform_state(pr384_pkg::OP_LINEAR, '0, '0);
    s.a_low     = 64'h1;
    s.b_high    = 64'h8000_0000_0000_0000;
    send_state(s);

    // random states, mostly defined operations
    for (int unsigned n = 0; n < NUM_ITEMS; n++) begin
      if (n == QUIET_FROM) begin
        idle_pct    = 0;
        squeeze_req = 1'b1;
      end
      if (n == QUIET_TO)
        idle_pct = IDLE_PCT;
      if ($urandom_range(0, 15) == 0)
        op = 3'($urandom_range(pr384_pkg::OP_LINEAR_T + 1, OP_MAX));
      else
        op = 3'($urandom_range(pr384_pkg::OP_ROUND_RC, pr384_pkg::OP_LINEAR_T));
      send_state(random_state(op, 5'($urandom_range(0, 31))));
    end
    req_valid = 1'b0;

    // drain
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
